FILE: src/dat_pkg.sv
package dat_pkg;

  // Field widths of one input item and one result item
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned FILL_W    = 7;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_READ_OK = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the accepted beat, clear the scan state
    logic scan_en;  // step the membership scan
    logic rd_en;    // read the entry at the requested index
    logic commit;   // update the table and load the result register
  } dat_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_insert;  // held operation is insert-if-absent
    logic read_ok;    // held operation is a read at a valid index
    logic scan_done;  // membership scan has finished
    logic out_free;   // result register can take a new beat
  } dat_sts_t;

endpackage

FILE: src/dat_ctrl.sv
module dat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output dat_pkg::dat_cmd_t cmd_o,
  input  dat_pkg::dat_sts_t sts_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DISP = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_RD   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       fin_q, fin_d;

  // Sequence one operation at a time
  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    if (fin_q) begin
      // Wait for room in the result register, then commit
      if (sts_i.out_free) begin
        cmd_o.commit = 1'b1;
        fin_d        = 1'b0;
        state_d      = S_IDLE;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = S_DISP;
          end
        end
        S_DISP: begin
          if (sts_i.is_insert) begin
            state_d = S_SCAN;
          end else if (sts_i.read_ok) begin
            state_d = S_RD;
          end else begin
            fin_d = 1'b1;
          end
        end
        S_SCAN: begin
          cmd_o.scan_en = 1'b1;
          if (sts_i.scan_done) begin
            fin_d = 1'b1;
          end
        end
        S_RD: begin
          cmd_o.rd_en = 1'b1;
          fin_d       = 1'b1;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

`ifndef SYNTHESIS
  // A commit always returns the controller to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (state_q == S_IDLE) && !fin_q)
    else $error("controller did not return to idle after commit");
  // The read state always hands over to the finish step on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) && !fin_q |=> fin_q)
    else $error("read state did not hand over to finish");
`endif

endmodule

FILE: src/dat_dpath.sv
module dat_dpath #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic        [dat_pkg::FUNC_W-1:0]    in_func_i,
  input  logic signed [dat_pkg::VALUE_W-1:0]   in_value_i,
  input  logic        [dat_pkg::INDEX_W-1:0]   in_index_i,
  input  dat_pkg::dat_cmd_t                    cmd_i,
  output dat_pkg::dat_sts_t                    sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [dat_pkg::STATUS_W-1:0]  out_status_o,
  output logic signed [dat_pkg::VALUE_W-1:0]   out_read_value_o,
  output logic        [dat_pkg::FILL_W-1:0]    out_fill_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > dat_pkg::INDEX_W) ? CW : dat_pkg::INDEX_W;
  localparam int unsigned EW = ELEMENT_WIDTH;

  // Table storage, written at the fill position, one read port
  logic signed [EW-1:0] mem_q [CAPACITY];

  logic        [dat_pkg::FUNC_W-1:0]   func_q;
  logic signed [EW-1:0]                elem_q;
  logic        [dat_pkg::INDEX_W-1:0]  index_q;
  logic        [CW-1:0]                count_q, count_d;
  logic        [CW-1:0]                ptr_q;
  logic                                rd_vld_q;
  logic                                found_q;
  logic signed [EW-1:0]                rdata_q;
  logic                                out_vld_q;
  logic        [dat_pkg::STATUS_W-1:0] out_status_q, status_d;
  logic signed [dat_pkg::VALUE_W-1:0]  out_rd_q, rd_value_d;
  logic        [dat_pkg::FILL_W-1:0]   out_fill_q;

  logic          scan_issue;
  logic          mem_rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] idx_addr;
  logic [XW-1:0] idx_x;
  logic [XW-1:0] cnt_x;
  logic          idx_ok;
  logic          full;
  logic          append_req;
  logic          do_write;
  logic          out_free;

  // Address and scan decode
  assign idx_x      = XW'(index_q);
  assign cnt_x      = XW'(count_q);
  assign idx_ok     = idx_x < cnt_x;
  assign idx_addr   = idx_x[AW-1:0];
  assign scan_issue = cmd_i.scan_en && (ptr_q < count_q);
  assign mem_rd_en  = scan_issue || cmd_i.rd_en;
  assign rd_addr    = cmd_i.scan_en ? ptr_q[AW-1:0] : idx_addr;
  assign full       = count_q == CW'(CAPACITY);
  assign out_free   = !out_vld_q || out_ready_i;

  assign append_req = (func_q == dat_pkg::FUNC_APPEND) ||
                      ((func_q == dat_pkg::FUNC_INSERT) && !found_q);
  assign do_write   = cmd_i.commit && append_req && !full;

  // Build the result of the held operation
  always_comb begin
    rd_value_d = '0;
    case (func_q)
      dat_pkg::FUNC_APPEND: begin
        status_d = full ? dat_pkg::ST_FULL : dat_pkg::ST_STORED;
      end
      dat_pkg::FUNC_INSERT: begin
        if (found_q) begin
          status_d = dat_pkg::ST_PRESENT;
        end else begin
          status_d = full ? dat_pkg::ST_FULL : dat_pkg::ST_STORED;
        end
      end
      dat_pkg::FUNC_READ: begin
        if (idx_ok) begin
          status_d   = dat_pkg::ST_READ_OK;
          rd_value_d = dat_pkg::VALUE_W'(rdata_q);
        end else begin
          status_d = dat_pkg::ST_BAD;
        end
      end
      default: begin
        status_d = dat_pkg::ST_BAD;
      end
    endcase
  end

  assign count_d = do_write ? count_q + CW'(1) : count_q;

  // Capture the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= in_func_i;
      elem_q  <= EW'(in_value_i);
      index_q <= in_index_i;
    end
  end

  // Write at the fill position, read for scan or indexed read
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[count_q[AW-1:0]] <= elem_q;
    end
    if (mem_rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Fill count and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load) begin
        ptr_q    <= '0;
        rd_vld_q <= 1'b0;
        found_q  <= 1'b0;
      end else begin
        if (scan_issue) begin
          ptr_q <= ptr_q + CW'(1);
        end
        rd_vld_q <= scan_issue;
        if (rd_vld_q && (rdata_q == elem_q)) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // Result register: load on commit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= status_d;
      out_rd_q     <= rd_value_d;
      out_fill_q   <= dat_pkg::FILL_W'(count_d);
    end
  end

  assign sts_o.is_insert = func_q == dat_pkg::FUNC_INSERT;
  assign sts_o.read_ok   = (func_q == dat_pkg::FUNC_READ) && idx_ok;
  assign sts_o.scan_done = found_q || (!(ptr_q < count_q) && !rd_vld_q);
  assign sts_o.out_free  = out_free;

  assign out_valid_o      = out_vld_q;
  assign out_status_o     = out_status_q;
  assign out_read_value_o = out_rd_q;
  assign out_fill_count_o = out_fill_q;

`ifndef SYNTHESIS
  // The fill count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count beyond capacity");
  // A commit never overwrites a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_vld_q || out_ready_i))
    else $error("result overwritten before it was taken");
  // The fill count moves only on a commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(count_q))
    else $error("fill count changed without a commit");
  // The scan never reads past the fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_en |-> ptr_q <= count_q)
    else $error("scan pointer beyond fill count");
`endif

endmodule

FILE: src/dedup_append_table.sv
// Deduplicating append table.
// The slave stream carries one operation per beat: tuser selects plain
// append, insert-if-absent or read at index; tdata holds the value and the
// read index. The master stream returns exactly one result beat per input
// beat, with the status code in tuser and the read value and the fill count
// after the operation in tdata.
// One operation is in flight at a time. A plain append and a rejected
// operation go from acceptance through a dispatch step to the commit; an
// indexed read adds a table read step. An insert-if-absent scans the
// stored entries through the single table read port, one entry per cycle,
// before it commits; a hit ends the scan early. The next beat is accepted
// the cycle after the result is loaded into the output register.
// When the receiver stalls, the result waits in the output register while
// the next beat is still accepted and worked on; its commit then waits until
// the output register is free.
// Reset empties the table (fill count zero) and drops any pending result;
// table contents are not cleared, since only entries below the fill count
// are ever read.
module dedup_append_table #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [31:0] value, [37:32] index, [39:38] zero
  input  logic [dat_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // [1:0] func
  input  logic [dat_pkg::FUNC_W-1:0]      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] read_value, [38:32] fill_count, [39] zero
  output logic [dat_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // [2:0] status
  output logic [dat_pkg::STATUS_W-1:0]    m_axis_tuser_o
);

  dat_pkg::dat_cmd_t cmd;
  dat_pkg::dat_sts_t sts;

  logic signed [dat_pkg::VALUE_W-1:0] in_value;
  logic        [dat_pkg::INDEX_W-1:0] in_index;
  logic signed [dat_pkg::VALUE_W-1:0] out_read_value;
  logic        [dat_pkg::FILL_W-1:0]  out_fill_count;

  // Unpack the input beat
  assign in_value = s_axis_tdata_i[dat_pkg::VALUE_W-1:0];
  assign in_index = s_axis_tdata_i[dat_pkg::VALUE_W +: dat_pkg::INDEX_W];

  dat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  dat_dpath #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_func_i        (s_axis_tuser_i),
    .in_value_i       (in_value),
    .in_index_i       (in_index),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_status_o     (m_axis_tuser_o),
    .out_read_value_o (out_read_value),
    .out_fill_count_o (out_fill_count)
  );

  // Pack the result beat
  assign m_axis_tdata_o = {1'b0, out_fill_count, out_read_value};

endmodule

FILE: tb/sv/dat_tb_pkg.sv
package dat_tb_pkg;

  import dat_pkg::*;

  // Table depth of the instance under test
  localparam int unsigned TABLE_DEPTH = 64;

  // Operation code the block leaves unused; it must be rejected
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // One result beat, fields in the order they are compared
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [FILL_W-1:0]   fill_count;
  } table_result_t;

  // Shadow copy of the table and the queue of results it predicts
  class table_scoreboard;
    logic [VALUE_W-1:0] stored [TABLE_DEPTH];
    int unsigned        fill;
    table_result_t      awaited [$];
    int unsigned        failures;
    int unsigned        checked;
    int unsigned        status_hits [8];

    function new();
      fill     = 0;
      failures = 0;
      checked  = 0;
      foreach (status_hits[k]) status_hits[k] = 0;
    endfunction

    // Append at the end unless the table is full
    function logic [STATUS_W-1:0] push_value(logic [VALUE_W-1:0] val);
      if (fill >= TABLE_DEPTH) return ST_FULL;
      stored[fill] = val;
      fill++;
      return ST_STORED;
    endfunction

    // Apply one accepted operation and queue the result it must give
    function void note_op(logic [FUNC_W-1:0] op, logic [VALUE_W-1:0] val,
                          logic [INDEX_W-1:0] idx);
      table_result_t exp_r;
      bit            hit;
      int unsigned   k;
      exp_r = '0;
      hit   = 1'b0;
      case (op)
        FUNC_APPEND: begin
          exp_r.status = push_value(val);
        end
        FUNC_INSERT: begin
          // membership is checked before fullness
          for (k = 0; k < fill; k++) begin
            if (stored[k] == val) hit = 1'b1;
          end
          exp_r.status = hit ? ST_PRESENT : push_value(val);
        end
        FUNC_READ: begin
          if (idx < fill) begin
            exp_r.status     = ST_READ_OK;
            exp_r.read_value = stored[idx];
          end else begin
            exp_r.status = ST_BAD;
          end
        end
        default: begin
          exp_r.status = ST_BAD;
        end
      endcase
      exp_r.fill_count = FILL_W'(fill);
      awaited.push_back(exp_r);
    endfunction

    // Compare one result beat with the oldest prediction
    function void check_result(time stamp, table_result_t got);
      table_result_t exp_r;
      if (awaited.size() == 0) begin
        $display("%0t ns: unexpected result beat: status %0d read_value %h fill %0d",
                 stamp, got.status, got.read_value, got.fill_count);
        failures++;
        return;
      end
      exp_r = awaited.pop_front();
      checked++;
      status_hits[exp_r.status]++;
      if (got.status !== exp_r.status) begin
        $display("%0t ns: status mismatch: expected %0d, actual %0d",
                 stamp, exp_r.status, got.status);
        failures++;
      end
      if (got.read_value !== exp_r.read_value) begin
        $display("%0t ns: read_value mismatch: expected %h, actual %h",
                 stamp, exp_r.read_value, got.read_value);
        failures++;
      end
      if (got.fill_count !== exp_r.fill_count) begin
        $display("%0t ns: fill_count mismatch: expected %0d, actual %0d",
                 stamp, exp_r.fill_count, got.fill_count);
        failures++;
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/dedup_append_table_tb.sv
module dedup_append_table_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import dat_pkg::*;
  import dat_tb_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned ITEM_COUNT   = 1700;
  localparam int unsigned IDLE_PCT     = 38;
  localparam int unsigned STEADY_FIRST = 700;
  localparam int unsigned STEADY_LAST  = 1000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned QUIET_LIMIT  = 4000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;   // [31:0] value, [37:32] index, [39:38] zero
  logic [FUNC_W-1:0]    s_axis_tuser_i;   // [1:0] func
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;   // [31:0] read_value, [38:32] fill_count, [39] zero
  logic [STATUS_W-1:0]  m_axis_tuser_o;   // [2:0] status

  table_scoreboard sb;
  bit              steady;
  int unsigned     ops_sent;
  int unsigned     quiet_cycles;

  dedup_append_table #(
    .CAPACITY     (TABLE_DEPTH),
    .ELEMENT_WIDTH(VALUE_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Stall the result stream at random, except during the steady stretch
  always @(negedge clk_i) begin
    m_axis_tready_i <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Check every result beat taken
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result($time, {m_axis_tuser_o, m_axis_tdata_o[VALUE_W-1:0],
                              m_axis_tdata_o[VALUE_W+FILL_W-1:VALUE_W]});
    end
  end

  // End the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Drive one operation beat, with random gaps ahead of it
  task automatic send_op(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] val,
                         input logic [INDEX_W-1:0] idx);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {2'b00, idx, val};
    s_axis_tuser_i  = op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_op(op, val, idx);
    ops_sent++;
  endtask

  // Favor table growth until full, then lookups and reads
  function automatic logic [FUNC_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sb.fill < TABLE_DEPTH) begin
      if (r < 40) return FUNC_APPEND;
      if (r < 75) return FUNC_INSERT;
      if (r < 95) return FUNC_READ;
      return FUNC_UNUSED;
    end
    if (r < 15) return FUNC_APPEND;
    if (r < 55) return FUNC_INSERT;
    if (r < 93) return FUNC_READ;
    return FUNC_UNUSED;
  endfunction

  // Mix stored values (hits at any position) with extremes and fresh words
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45 && sb.fill > 0) return sb.stored[$urandom_range(0, sb.fill - 1)];
    if (r < 55) begin
      case ($urandom_range(0, 4))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        3:       return 32'hffff_ffff;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if (sb.fill > 0 && $urandom_range(0, 99) < 80) return INDEX_W'($urandom_range(0, sb.fill - 1));
    return INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
  endfunction

  initial begin
    sb              = new();
    steady          = 1'b0;
    ops_sent        = 0;
    quiet_cycles    = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = FUNC_APPEND;
    m_axis_tready_i = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table: every read and the unused code are rejected
    send_op(FUNC_READ,   32'h0000_0000, 6'd0);
    send_op(FUNC_READ,   32'hffff_ffff, 6'd63);
    send_op(FUNC_UNUSED, 32'h0000_0000, 6'd0);
    // Inserts hit or miss, a plain append stores a duplicate
    send_op(FUNC_INSERT, 32'h8000_0000, 6'd0);
    send_op(FUNC_INSERT, 32'h8000_0000, 6'd63);
    send_op(FUNC_APPEND, 32'h8000_0000, 6'd0);
    send_op(FUNC_INSERT, 32'h7fff_ffff, 6'd0);
    send_op(FUNC_APPEND, 32'h0000_0000, 6'd0);
    send_op(FUNC_INSERT, 32'h0000_0000, 6'd0);
    send_op(FUNC_INSERT, 32'hffff_ffff, 6'd0);
    send_op(FUNC_INSERT, 32'h7fff_ffff, 6'd0);
    // Reads at the first and last entry, at the count and past it
    send_op(FUNC_READ,   32'h0000_0000, 6'd0);
    send_op(FUNC_READ,   32'h0000_0000, 6'd4);
    send_op(FUNC_READ,   32'h0000_0000, 6'd5);
    send_op(FUNC_READ,   32'hffff_ffff, 6'd63);
    send_op(FUNC_UNUSED, 32'hffff_ffff, 6'd63);

    // Random traffic: grow to full, then keep hammering the full table
    for (int unsigned i = 0; i < ITEM_COUNT; i++) begin
      steady = (i >= STEADY_FIRST) && (i < STEADY_LAST);
      send_op(pick_op(), pick_value(), pick_index());
    end
    steady = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;

    // Drain, then give any stray beat time to show up
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d operations, checked %0d results, final fill %0d of %0d",
             ops_sent, sb.checked, sb.fill, TABLE_DEPTH);
    $display("Status seen: stored %0d, present %0d, full %0d, read ok %0d, rejected %0d",
             sb.status_hits[ST_STORED], sb.status_hits[ST_PRESENT], sb.status_hits[ST_FULL],
             sb.status_hits[ST_READ_OK], sb.status_hits[ST_BAD]);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
